// ----- rtl/flpte_pkg.sv -----
// Shared types and constants for the four-level page table enumerator.
package flpte_pkg;

    localparam int PHYS_ADDR_BITS = 48;
    localparam logic [63:0] PHYS_MASK = (64'd1 << PHYS_ADDR_BITS) - 64'd1;

    localparam int VA_BITS   = 48;
    localparam int IDX_BITS  = 9;
    localparam int BASE_BITS = 36;
    localparam int LEVELS    = 4;
    localparam int PADDR_BITS = 5;

    localparam logic [IDX_BITS-1:0] IDX_MAX   = 9'd511;
    localparam logic [IDX_BITS-1:0] FIXUP_IDX = 9'd510;
    localparam logic [VA_BITS-1:0]  VA_MASK   = 48'hffff_ffff_ffff;

    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    localparam logic [1:0] REG_ROOT  = 2'd0;
    localparam logic [1:0] REG_BEGIN = 2'd1;
    localparam logic [1:0] REG_END   = 2'd2;

    localparam int ENTRY_PRESENT = 0;
    localparam int ENTRY_LARGE   = 7;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_DATA  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_PAGE = 2'd1,
        OP_END  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        SZ_4K = 2'd0,
        SZ_2M = 2'd1,
        SZ_1G = 2'd2
    } t_size;

    typedef struct packed {
        t_op                op;
        logic [VA_BITS-1:0] phys;
        logic [VA_BITS-1:0] virt;
        t_size              size;
        logic               failed;
        logic               last;
    } t_result;

endpackage

// ----- rtl/four_level_page_table_enumerator.sv -----
// Page table walker that lists every mapped page of a virtual range.
// A result enters the registered output queue at the edge that accepts its item. Throughput:
// one item per cycle when it causes one result and the output is not held by i_stall;
// an item that finds a page gives two results and the two-slot headroom of the three-entry
// output queue sets the sustained rate. Reset (synchronous, active low) clears the walk
// state, the output queue and the registers (range_end to all ones).
module four_level_page_table_enumerator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [flpte_pkg::PADDR_BITS-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [63:0] i_entry,
    input  logic        i_read_failed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_op,
    output logic [47:0] o_phys_address,
    output logic [47:0] o_virt_address,
    output logic [1:0]  o_page_size,
    output logic        o_failed,
    output logic        o_last
);

    localparam int IB = flpte_pkg::IDX_BITS;
    localparam int BB = flpte_pkg::BASE_BITS;
    localparam int VB = flpte_pkg::VA_BITS;
    localparam int NL = flpte_pkg::LEVELS;

    logic [VB-1:0] r_root, r_range_begin, r_range_end;
    logic          r_walking, n_walking;
    logic [1:0]    r_depth, n_depth;
    logic [IB-1:0] r_idx [NL];
    logic [IB-1:0] n_idx [NL];
    logic [BB-1:0] r_base [NL];
    logic [BB-1:0] n_base [NL];
    logic [NL-1:0] r_low, n_low, r_high, n_high;

    flpte_pkg::t_result r_q [3];
    flpte_pkg::t_result n_q [3];
    logic [1:0]         r_count, n_count;

    logic          cfg_wr, acc, pop;
    logic [1:0]    base_cnt;
    logic [IB-1:0] bf [NL];
    logic [IB-1:0] ef [NL];
    logic [NL-1:0] fin;
    logic          adv_found;
    logic [1:0]    adv_lvl;
    logic [IB-1:0] adv_idx;
    logic [63:0]   pa;
    logic [1:0]    nd;
    logic          descend;
    logic [IB-1:0] nd_idx;
    logic          nd_low, nd_high;
    flpte_pkg::t_result res0, res1, adv_res;
    logic [1:0]    n_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = 64'd0;
        case (paddr[4:3])
            flpte_pkg::REG_ROOT:  prdata = {16'd0, r_root};
            flpte_pkg::REG_BEGIN: prdata = {16'd0, r_range_begin};
            flpte_pkg::REG_END:   prdata = {16'd0, r_range_end};
            default:              prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root        <= '0;
            r_range_begin <= '0;
            r_range_end   <= flpte_pkg::VA_MASK;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                flpte_pkg::REG_ROOT:  r_root        <= pwdata[VB-1:0];
                flpte_pkg::REG_BEGIN: r_range_begin <= pwdata[VB-1:0];
                flpte_pkg::REG_END:   r_range_end   <= pwdata[VB-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign o_valid  = (r_count != 2'd0);
    assign pop      = o_valid && !i_stall;
    assign base_cnt = r_count - {1'b0, pop};
    assign o_stall  = (base_cnt > 2'd1);
    assign acc      = i_valid && !o_stall;

    assign o_op           = r_q[0].op;
    assign o_phys_address = r_q[0].phys;
    assign o_virt_address = r_q[0].virt;
    assign o_page_size    = r_q[0].size;
    assign o_failed       = r_q[0].failed;
    assign o_last         = r_q[0].last;

    // per-level range fields and finished-table flags
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            bf[l]  = r_range_begin[39-9*l +: IB];
            ef[l]  = r_range_end[39-9*l +: IB];
            fin[l] = (r_high[l] && r_idx[l] == ef[l]) || r_idx[l] == flpte_pkg::IDX_MAX;
        end
    end

    // climb out of finished tables to the deepest level with entries left
    always_comb begin
        adv_found = 1'b0;
        adv_lvl   = 2'd0;
        for (int l = 0; l < NL; l++) begin
            if (2'(l) <= r_depth && !fin[l]) begin
                adv_found = 1'b1;
                adv_lvl   = 2'(l);
            end
        end
        adv_idx = r_idx[adv_lvl] + 9'd1;
        adv_res = '{op: flpte_pkg::OP_END, phys: '0, virt: '0,
                    size: flpte_pkg::SZ_4K, failed: 1'b0, last: 1'b1};
        if (adv_found) begin
            adv_res.op   = flpte_pkg::OP_READ;
            adv_res.phys = {r_base[adv_lvl], adv_idx, 3'b000};
        end
    end

    always_comb begin
        pa      = i_entry & flpte_pkg::PHYS_MASK;
        nd      = r_depth + 2'd1;
        descend = i_entry[flpte_pkg::ENTRY_PRESENT]
                  && r_depth != flpte_pkg::LVL_PT
                  && !((r_depth == flpte_pkg::LVL_PDPT || r_depth == flpte_pkg::LVL_PD)
                       && i_entry[flpte_pkg::ENTRY_LARGE])
                  && !(r_depth == flpte_pkg::LVL_PD && r_idx[0] == flpte_pkg::FIXUP_IDX);
        nd_low  = r_low[r_depth] && r_idx[r_depth] == bf[r_depth];
        nd_high = r_high[r_depth] && r_idx[r_depth] == ef[r_depth];
        nd_idx  = nd_low ? bf[nd] : '0;
    end

    // results and state update of one transfer
    always_comb begin
        n_walking = r_walking;
        n_depth   = r_depth;
        n_low     = r_low;
        n_high    = r_high;
        for (int l = 0; l < NL; l++) begin
            n_idx[l]  = r_idx[l];
            n_base[l] = r_base[l];
        end
        res0  = adv_res;
        res1  = adv_res;
        n_res = 2'd0;
        if (i_kind == flpte_pkg::KIND_START) begin
            n_depth   = flpte_pkg::LVL_PML4;
            n_base[0] = r_root[VB-1:12];
            n_idx[0]  = bf[0];
            n_low[0]  = 1'b1;
            n_high[0] = 1'b1;
            n_res     = 2'd1;
            if (r_range_begin > r_range_end) begin
                n_walking = 1'b0;
                res0 = '{op: flpte_pkg::OP_END, phys: '0, virt: '0,
                         size: flpte_pkg::SZ_4K, failed: 1'b0, last: 1'b1};
            end else begin
                n_walking = 1'b1;
                res0 = '{op: flpte_pkg::OP_READ, phys: {r_root[VB-1:12], bf[0], 3'b000},
                         virt: '0, size: flpte_pkg::SZ_4K, failed: 1'b0, last: 1'b1};
            end
        end else if (r_walking) begin
            n_res = 2'd1;
            if (i_read_failed) begin
                n_walking = 1'b0;
                res0 = '{op: flpte_pkg::OP_END, phys: '0, virt: '0,
                         size: flpte_pkg::SZ_4K, failed: 1'b1, last: 1'b1};
            end else if (descend) begin
                n_base[nd] = pa[VB-1:12];
                n_low[nd]  = nd_low;
                n_high[nd] = nd_high;
                n_idx[nd]  = nd_idx;
                n_depth    = nd;
                res0 = '{op: flpte_pkg::OP_READ, phys: {pa[VB-1:12], nd_idx, 3'b000},
                         virt: '0, size: flpte_pkg::SZ_4K, failed: 1'b0, last: 1'b1};
            end else begin
                if (i_entry[flpte_pkg::ENTRY_PRESENT] && r_depth != flpte_pkg::LVL_PML4
                    && !(r_depth == flpte_pkg::LVL_PD && r_idx[0] == flpte_pkg::FIXUP_IDX
                         && !i_entry[flpte_pkg::ENTRY_LARGE])) begin
                    n_res = 2'd2;
                    res0.op     = flpte_pkg::OP_PAGE;
                    res0.failed = 1'b0;
                    res0.last   = 1'b0;
                    case (r_depth)
                        flpte_pkg::LVL_PDPT: begin
                            res0.phys = {pa[VB-1:30], 30'd0};
                            res0.virt = {r_idx[0], r_idx[1], 30'd0};
                            res0.size = flpte_pkg::SZ_1G;
                        end
                        flpte_pkg::LVL_PD: begin
                            res0.phys = {pa[VB-1:21], 21'd0};
                            res0.virt = {r_idx[0], r_idx[1], r_idx[2], 21'd0};
                            res0.size = flpte_pkg::SZ_2M;
                        end
                        default: begin
                            res0.phys = {pa[VB-1:12], 12'd0};
                            res0.virt = {r_idx[0], r_idx[1], r_idx[2], r_idx[3], 12'd0};
                            res0.size = flpte_pkg::SZ_4K;
                        end
                    endcase
                end
                if (adv_found) begin
                    n_idx[adv_lvl] = adv_idx;
                    n_depth        = adv_lvl;
                end else begin
                    n_walking = 1'b0;
                    n_depth   = flpte_pkg::LVL_PML4;
                end
            end
        end
    end

    // output queue: shift on pop, append results behind what remains
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
        n_count = base_cnt;
        if (acc) begin
            for (int i = 0; i < 3; i++) begin
                if (n_res != 2'd0 && 2'(i) == base_cnt) begin
                    n_q[i] = res0;
                end
                if (n_res == 2'd2 && 2'(i) == base_cnt + 2'd1) begin
                    n_q[i] = res1;
                end
            end
            n_count = base_cnt + n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking <= 1'b0;
            r_depth   <= '0;
            r_low     <= '0;
            r_high    <= '0;
            r_count   <= '0;
            for (int l = 0; l < NL; l++) begin
                r_idx[l] <= '0;
            end
        end else begin
            r_count <= n_count;
            if (acc) begin
                r_walking <= n_walking;
                r_depth   <= n_depth;
                r_low     <= n_low;
                r_high    <= n_high;
                for (int l = 0; l < NL; l++) begin
                    r_idx[l] <= n_idx[l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_q[i] <= n_q[i];
        end
        if (acc) begin
            for (int l = 0; l < NL; l++) begin
                r_base[l] <= n_base[l];
            end
        end
    end

    a_end_stops_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && n_res != 2'd0 && res0.op == flpte_pkg::OP_END |=> !r_walking)
        else $error("walk still active after walk-ended result");

    a_descend_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_kind == flpte_pkg::KIND_DATA && r_walking && !i_read_failed && descend
        |=> r_depth == $past(r_depth) + 2'd1)
        else $error("descent did not move one level down");

    a_page_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_op == flpte_pkg::OP_PAGE |-> !o_last)
        else $error("page result marked as last of its item");

endmodule

// ----- tb/tb_four_level_page_table_enumerator.sv -----
// Self-checking testbench for the four-level page table enumerator walk engine.
module tb_four_level_page_table_enumerator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IB = flpte_pkg::IDX_BITS;
    localparam int BB = flpte_pkg::BASE_BITS;

    typedef struct {
        flpte_pkg::t_kind kind;
        logic [63:0]      entry;
        logic             rfail;
    } t_walk_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [flpte_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [63:0] i_entry = '0;
    logic        i_read_failed = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_op;
    logic [47:0] o_phys_address;
    logic [47:0] o_virt_address;
    logic [1:0]  o_page_size;
    logic        o_failed;
    logic        o_last;

    four_level_page_table_enumerator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_entry(i_entry), .i_read_failed(i_read_failed),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_op(o_op), .o_phys_address(o_phys_address), .o_virt_address(o_virt_address),
        .o_page_size(o_page_size), .o_failed(o_failed), .o_last(o_last)
    );

    // walk state mirror
    logic [47:0] cfg_root = '0;
    logic [47:0] cfg_begin = '0;
    logic [47:0] cfg_end = flpte_pkg::VA_MASK;
    logic        pr_walking = 1'b0;
    logic [1:0]  pr_depth = flpte_pkg::LVL_PML4;
    logic [IB-1:0] pr_idx [flpte_pkg::LEVELS] = '{default: '0};
    logic [BB-1:0] pr_base [flpte_pkg::LEVELS];
    logic        pr_lo [flpte_pkg::LEVELS] = '{default: 1'b0};
    logic        pr_hi [flpte_pkg::LEVELS] = '{default: 1'b0};

    t_walk_item          walk_inputs[$];
    flpte_pkg::t_result  walk_results_due[$];
    int         useful_items = 0;
    int         errors = 0;
    int         gap_left = -1;
    int         stall_left = 0;
    logic       no_idle = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("four_level_page_table_enumerator test failed");
        $finish;
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [IB-1:0] va_field(logic [47:0] a, logic [1:0] lvl);
        return IB'(a >> (39 - 9 * int'(lvl)));
    endfunction

    function automatic logic [47:0] table_slot(logic [1:0] d);
        return {pr_base[d], pr_idx[d], 3'b000};
    endfunction

    function automatic logic [47:0] page_virt(logic [1:0] d);
        logic [47:0] v;
        v = '0;
        for (int i = 0; i <= int'(d); i++) v |= 48'(pr_idx[i]) << (39 - 9 * i);
        return v;
    endfunction

    function automatic flpte_pkg::t_result mk_result(flpte_pkg::t_op op, logic [47:0] phys,
                                                     logic [47:0] virt,
                                                     flpte_pkg::t_size size, logic failed);
        flpte_pkg::t_result r;
        r.op = op;
        r.phys = phys;
        r.virt = virt;
        r.size = size;
        r.failed = failed;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic [63:0] make_entry();
        logic [63:0] e;
        e = {$urandom, $urandom};
        e[flpte_pkg::ENTRY_PRESENT] = ($urandom_range(0, 3) != 0);
        e[flpte_pkg::ENTRY_LARGE] = ($urandom_range(0, 2) == 0);
        return e;
    endfunction

    task automatic walk_step(flpte_pkg::t_kind kind, logic [63:0] e, logic rfail);
        flpte_pkg::t_result outs[$];
        logic [1:0] d;
        logic [1:0] nd;
        logic [63:0] pa;
        logic descend;
        logic climbing;
        descend = 1'b0;
        if (kind == flpte_pkg::KIND_START) begin
            useful_items++;
            pr_depth = flpte_pkg::LVL_PML4;
            pr_base[flpte_pkg::LVL_PML4] = cfg_root[47:12];
            pr_idx[flpte_pkg::LVL_PML4] = va_field(cfg_begin, flpte_pkg::LVL_PML4);
            pr_lo[flpte_pkg::LVL_PML4] = 1'b1;
            pr_hi[flpte_pkg::LVL_PML4] = 1'b1;
            if (cfg_begin > cfg_end) begin
                pr_walking = 1'b0;
                outs.push_back(mk_result(flpte_pkg::OP_END, '0, '0, flpte_pkg::SZ_4K, 1'b0));
            end else begin
                pr_walking = 1'b1;
                outs.push_back(mk_result(flpte_pkg::OP_READ, table_slot(flpte_pkg::LVL_PML4),
                                         '0, flpte_pkg::SZ_4K, 1'b0));
            end
        end else if (pr_walking) begin
            useful_items++;
            if (rfail) begin
                pr_walking = 1'b0;
                outs.push_back(mk_result(flpte_pkg::OP_END, '0, '0, flpte_pkg::SZ_4K, 1'b1));
            end else begin
                d = pr_depth;
                pa = e & flpte_pkg::PHYS_MASK;
                if (e[flpte_pkg::ENTRY_PRESENT]) begin
                    if (d == flpte_pkg::LVL_PT) begin
                        outs.push_back(mk_result(flpte_pkg::OP_PAGE, 48'(pa & ~64'hfff),
                                                 page_virt(d), flpte_pkg::SZ_4K, 1'b0));
                    end else if (d == flpte_pkg::LVL_PDPT && e[flpte_pkg::ENTRY_LARGE]) begin
                        outs.push_back(mk_result(flpte_pkg::OP_PAGE,
                                                 48'(pa & ~((64'd1 << 30) - 64'd1)),
                                                 page_virt(d), flpte_pkg::SZ_1G, 1'b0));
                    end else if (d == flpte_pkg::LVL_PD && e[flpte_pkg::ENTRY_LARGE]) begin
                        outs.push_back(mk_result(flpte_pkg::OP_PAGE,
                                                 48'(pa & ~((64'd1 << 21) - 64'd1)),
                                                 page_virt(d), flpte_pkg::SZ_2M, 1'b0));
                    end else if (d == flpte_pkg::LVL_PD &&
                                 pr_idx[flpte_pkg::LVL_PML4] == flpte_pkg::FIXUP_IDX) begin
                        // skip: no PT under the fixup slot
                    end else begin
                        nd = d + 2'd1;
                        pr_base[nd] = BB'(pa >> 12);
                        pr_lo[nd] = pr_lo[d] && pr_idx[d] == va_field(cfg_begin, d);
                        pr_hi[nd] = pr_hi[d] && pr_idx[d] == va_field(cfg_end, d);
                        pr_idx[nd] = pr_lo[nd] ? va_field(cfg_begin, nd) : '0;
                        pr_depth = nd;
                        outs.push_back(mk_result(flpte_pkg::OP_READ, table_slot(nd), '0,
                                                 flpte_pkg::SZ_4K, 1'b0));
                        descend = 1'b1;
                    end
                end
                if (!descend) begin
                    climbing = 1'b1;
                    while (climbing) begin
                        d = pr_depth;
                        if ((pr_hi[d] && pr_idx[d] == va_field(cfg_end, d)) ||
                            pr_idx[d] >= flpte_pkg::IDX_MAX) begin
                            if (d == flpte_pkg::LVL_PML4) begin
                                pr_walking = 1'b0;
                                outs.push_back(mk_result(flpte_pkg::OP_END, '0, '0,
                                                         flpte_pkg::SZ_4K, 1'b0));
                                climbing = 1'b0;
                            end else begin
                                pr_depth = d - 2'd1;
                            end
                        end else begin
                            pr_idx[d] = pr_idx[d] + IB'(1);
                            outs.push_back(mk_result(flpte_pkg::OP_READ, table_slot(d), '0,
                                                     flpte_pkg::SZ_4K, 1'b0));
                            climbing = 1'b0;
                        end
                    end
                end
            end
        end
        if (outs.size() > 0) begin
            outs[outs.size() - 1].last = 1'b1;
            foreach (outs[i]) walk_results_due.push_back(outs[i]);
        end
    endtask

    task automatic note_mismatch(string what);
        errors++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : feed
        t_walk_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = -1;
        end else begin
            if (i_valid && !o_stall)
                walk_step(flpte_pkg::t_kind'(i_kind), i_entry, i_read_failed);
            if (!i_valid || !o_stall) begin
                if (walk_inputs.size() > 0 && gap_left < 0)
                    gap_left = no_idle ? 0 : $urandom_range(0, 15);
                if (walk_inputs.size() > 0 && gap_left == 0) begin
                    nxt = walk_inputs.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= nxt.kind;
                    i_entry <= nxt.entry;
                    i_read_failed <= nxt.rfail;
                    gap_left = -1;
                end else begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        flpte_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (walk_results_due.size() == 0) begin
                    note_mismatch($sformatf("result op %0d with none due", o_op));
                end else begin
                    want = walk_results_due.pop_front();
                    check_field("op", 64'(o_op), 64'(want.op));
                    check_field("phys_address", 64'(o_phys_address), 64'(want.phys));
                    check_field("virt_address", 64'(o_virt_address), 64'(want.virt));
                    check_field("page_size", 64'(o_page_size), 64'(want.size));
                    check_field("failed", 64'(o_failed), 64'(want.failed));
                    check_field("last", 64'(o_last), 64'(want.last));
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (walk_inputs.size() != 0 || i_valid || walk_results_due.size() != 0);
    endtask

    task automatic push_item(flpte_pkg::t_kind kind, logic [63:0] entry, logic rfail);
        t_walk_item it;
        it.kind = kind;
        it.entry = entry;
        it.rfail = rfail;
        walk_inputs.push_back(it);
    endtask

    task automatic send(flpte_pkg::t_kind kind, logic [63:0] entry, logic rfail);
        wait_idle();
        push_item(kind, entry, rfail);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == flpte_pkg::REG_ROOT) cfg_root = val;
        else if (idx == flpte_pkg::REG_BEGIN) cfg_begin = val;
        else if (idx == flpte_pkg::REG_END) cfg_end = val;
    endtask

    task automatic set_range(logic [47:0] root, logic [47:0] va_lo, logic [47:0] va_hi);
        wait_idle();
        repeat (4) @(posedge i_clk);
        write_reg(flpte_pkg::REG_ROOT, root);
        write_reg(flpte_pkg::REG_BEGIN, va_lo);
        write_reg(flpte_pkg::REG_END, va_hi);
    endtask

    task automatic run_walk();
        int cap;
        send(flpte_pkg::KIND_START, {$urandom, $urandom}, $urandom_range(0, 7) == 0);
        cap = $urandom_range(1, 100);
        for (int steps = 0; steps < cap; steps++) begin
            wait_idle();
            if (!pr_walking) break;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(2, 6))
                    push_item(flpte_pkg::KIND_DATA, make_entry(), $urandom_range(0, 15) == 0);
            end else begin
                push_item(flpte_pkg::KIND_DATA, make_entry(), $urandom_range(0, 50) == 0);
            end
        end
        if ($urandom_range(0, 4) == 0)
            send(flpte_pkg::KIND_DATA, make_entry(), 1'($urandom_range(0, 1)));
    endtask

    localparam logic [63:0] TBL  = 64'h0000_0000_0012_3003;
    localparam logic [63:0] BIG  = 64'h8000_00ab_cde0_0083;
    localparam logic [63:0] WIDE = 64'hfff0_0000_4000_0001;

    initial begin : stimulus
        int base;
        logic [47:0] r_begin;
        logic [48:0] sum;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: stray data, start with read_failed, masking, failed read
        send(flpte_pkg::KIND_DATA, make_entry(), 1'b0);
        send(flpte_pkg::KIND_START, '0, 1'b1);
        send(flpte_pkg::KIND_DATA, 64'h7fff_ffff_ffff_fffe, 1'b0);
        send(flpte_pkg::KIND_DATA, 64'hffff_ffff_ffff_ffff, 1'b0);
        send(flpte_pkg::KIND_DATA, '0, 1'b1);

        // empty range
        set_range('0, 48'd1, 48'd0);
        send(flpte_pkg::KIND_START, '0, 1'b0);

        // fixup slot: skipped PT, then 2M and 1G pages
        set_range(flpte_pkg::VA_MASK, {9'd510, 9'd3, 9'd511, 9'd511, 12'h000},
                  {9'd510, 9'd3, 9'd511, 9'd511, 12'h000});
        send(flpte_pkg::KIND_START, '0, 1'b0);
        send(flpte_pkg::KIND_DATA, BIG, 1'b0);
        send(flpte_pkg::KIND_DATA, TBL, 1'b0);
        send(flpte_pkg::KIND_DATA, WIDE, 1'b0);
        send(flpte_pkg::KIND_START, '0, 1'b0);
        send(flpte_pkg::KIND_DATA, TBL, 1'b0);
        send(flpte_pkg::KIND_DATA, TBL, 1'b0);
        send(flpte_pkg::KIND_DATA, BIG, 1'b0);
        send(flpte_pkg::KIND_START, '0, 1'b0);
        send(flpte_pkg::KIND_DATA, WIDE, 1'b0);
        send(flpte_pkg::KIND_DATA, BIG, 1'b0);

        // 4K pages across a PT edge, then restart mid-walk
        set_range('0, {9'd0, 9'd0, 9'd0, 9'd510, 12'h000}, {9'd0, 9'd0, 9'd1, 9'd3, 12'hfff});
        send(flpte_pkg::KIND_START, '0, 1'b0);
        send(flpte_pkg::KIND_DATA, TBL, 1'b0);
        send(flpte_pkg::KIND_DATA, WIDE, 1'b0);
        send(flpte_pkg::KIND_DATA, TBL, 1'b0);
        send(flpte_pkg::KIND_DATA, BIG, 1'b0);
        send(flpte_pkg::KIND_DATA, 64'hffff_ffff_ffff_ffff, 1'b0);
        send(flpte_pkg::KIND_DATA, TBL, 1'b0);
        send(flpte_pkg::KIND_DATA, 64'h0000_0000_0000_0080, 1'b0);
        send(flpte_pkg::KIND_START, '0, 1'b0);

        wait_idle();
        base = useful_items;
        for (int k = 0; k < 10; k++) begin
            if (k == 0) begin
                set_range(flpte_pkg::VA_MASK, '0, flpte_pkg::VA_MASK);
            end else if (k == 1) begin
                set_range('0, flpte_pkg::VA_MASK, flpte_pkg::VA_MASK);
            end else if (k == 2) begin
                set_range(rand48(), flpte_pkg::VA_MASK, '0);
            end else begin
                r_begin = rand48();
                sum = {1'b0, r_begin} + (49'(rand48()) >> $urandom_range(8, 47));
                set_range(rand48(), r_begin, sum[48] ? flpte_pkg::VA_MASK : sum[47:0]);
            end
            no_idle = (k == 3 || k == 6);
            while (useful_items < base + (k + 1) * 140) run_walk();
        end

        wait_idle();
        no_idle = 1'b0;
        repeat (10) @(posedge i_clk);
        if (walk_results_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", walk_results_due.size()));
        if (errors == 0) begin
            $display("four_level_page_table_enumerator test passed");
        end else begin
            $display("four_level_page_table_enumerator test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/flpte_pkg.sv
rtl/four_level_page_table_enumerator.sv
tb/tb_four_level_page_table_enumerator.sv
